@@ rtl/core/knds_pkg.sv @@
package knds_pkg;

  localparam int ID_W      = 16;
  localparam int COMP_W    = 16;
  localparam int DIFF_W    = COMP_W + 1;
  // the square of a 17-bit difference never exceeds 2^32
  localparam int SQ_W      = 2 * COMP_W + 1;
  localparam int DIST_W    = 48;
  localparam int K_W       = 5;

  localparam int MAX_KEPT_DEF = 16;

  localparam logic [K_W-1:0] K_RESET = K_W'(10);

  localparam logic CMD_COMPONENT = 1'b0;
  localparam logic CMD_FLUSH     = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [ID_W-1:0]          candidate_id;
    logic signed [COMP_W-1:0] query_component;
    logic signed [COMP_W-1:0] data_component;
    logic                     last_component;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [DIST_W-1:0] result_distance;
    logic              result_valid;
    logic              last_result;
  } out_item_t;

endpackage

@@ rtl/core/k_nearest_distance_selector.sv @@
// K-nearest selector. Each component request adds the squared difference of
// its query and data components to a saturating 48-bit distance; a request with
// last_component set offers that distance, with its candidate id, to a sorted
// store of at most K (1..MAX_KEPT) entries. One request is taken every clock
// unless in_stall holds it: a three-register pipeline (square, accumulate,
// store insertion by parallel compare) carries it, and a request passes the
// square and accumulate registers into the store. A flush request copies the
// store into an emission buffer and empties it in the same cycle, so components
// behind it keep flowing while the buffer drains one result per clock, unless
// out_stall holds it, through the output register. A flush of n entries gives
// n results (one invalid result when the store is empty). A second flush that
// reaches the store while the buffer still drains stalls the input until the
// buffer is empty. Write the K register only while the pipeline is drained.
module k_nearest_distance_selector
  import knds_pkg::*;
#(
  parameter int MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  in_item_t       in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output out_item_t      out_data,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int KW = (CW > K_W) ? CW : K_W;

  logic [K_W-1:0] k_r;

  // pipeline registers
  logic                     s1_vld_r;
  logic                     s1_cmd_r;
  logic                     s1_last_r;
  logic [ID_W-1:0]          s1_id_r;
  logic [SQ_W-1:0]          s1_sq_r;
  logic [DIST_W-1:0]        acc_r;
  logic [DIST_W-1:0]        acc_nxt;
  logic                     s2_vld_r;
  logic                     s2_flush_r;
  logic                     s2_ins_r;
  logic [ID_W-1:0]          s2_id_r;
  logic [DIST_W-1:0]        s2_dist_r;

  // sorted store and emission buffer
  logic [ID_W-1:0]          kept_id_r   [MAX_KEPT];
  logic [DIST_W-1:0]        kept_dist_r [MAX_KEPT];
  logic [ID_W-1:0]          kept_id_nxt   [MAX_KEPT];
  logic [DIST_W-1:0]        kept_dist_nxt [MAX_KEPT];
  logic [CW-1:0]            kept_cnt_r;
  logic [CW-1:0]            kept_cnt_nxt;
  logic [ID_W-1:0]          sh_id_r   [MAX_KEPT];
  logic [DIST_W-1:0]        sh_dist_r [MAX_KEPT];
  logic [CW-1:0]            sh_cnt_r;
  logic                     sh_empty_r;

  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic                     hold;
  logic                     in_fire;
  logic                     s1_fire;
  logic                     s2_fire;
  logic                     sh_busy;
  logic                     emit;
  logic signed [DIFF_W-1:0] diff;
  logic signed [2*DIFF_W-1:0] sq_full;
  logic [DIST_W:0]          sum;
  logic [DIST_W-1:0]        sat;
  logic [KW-1:0]            k_raw;
  logic [KW-1:0]            k_eff;
  logic                     full;
  logic [MAX_KEPT-1:0]      gt;
  logic [MAX_KEPT-1:0]      gt_real;
  logic [MAX_KEPT-1:0]      gt_prev;
  logic                     skip;
  logic                     do_ins;
  logic                     do_flush;
  logic [ID_W-1:0]          id_up   [MAX_KEPT];
  logic [DIST_W-1:0]        dist_up [MAX_KEPT];

  assign sh_busy  = (sh_cnt_r != '0) || sh_empty_r;
  assign hold     = s2_vld_r && s2_flush_r && sh_busy;
  assign in_stall = hold;
  assign in_fire  = in_valid && !hold;
  assign s1_fire  = s1_vld_r && !hold;
  assign s2_fire  = s2_vld_r && !hold;
  assign emit     = sh_busy && (!out_valid_r || !out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // square of the component difference
  assign diff    = DIFF_W'(in_data.query_component) - DIFF_W'(in_data.data_component);
  assign sq_full = diff * diff;

  // saturating accumulate
  assign sum = {1'b0, acc_r} + (DIST_W + 1)'(s1_sq_r);
  assign sat = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_comb begin
    acc_nxt = acc_r;
    if (s1_fire) begin
      if (s1_cmd_r == CMD_FLUSH || s1_last_r) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = sat;
      end
    end
  end

  // effective K: zero acts as one, above the store depth acts as the depth
  assign k_raw = KW'(k_r);
  always_comb begin
    if (k_raw == '0) begin
      k_eff = KW'(1);
    end else if (k_raw > KW'(MAX_KEPT)) begin
      k_eff = KW'(MAX_KEPT);
    end else begin
      k_eff = k_raw;
    end
  end
  assign full = KW'(kept_cnt_r) >= k_eff;

  // an entry past the fill count counts as larger than anything
  always_comb begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      gt_real[i] = (CW'(i) < kept_cnt_r) && (kept_dist_r[i] > s2_dist_r);
      gt[i]      = (CW'(i) >= kept_cnt_r) || (kept_dist_r[i] > s2_dist_r);
    end
  end
  assign gt_prev = gt << 1;
  assign skip    = full && !(|gt_real);

  assign do_ins   = s2_fire && s2_ins_r && !skip;
  assign do_flush = s2_fire && s2_flush_r;

  always_comb begin
    id_up[0]   = kept_id_r[0];
    dist_up[0] = kept_dist_r[0];
    for (int i = 1; i < MAX_KEPT; i++) begin
      id_up[i]   = kept_id_r[i-1];
      dist_up[i] = kept_dist_r[i-1];
    end
    for (int i = 0; i < MAX_KEPT; i++) begin
      if (!gt[i]) begin
        kept_id_nxt[i]   = kept_id_r[i];
        kept_dist_nxt[i] = kept_dist_r[i];
      end else if (gt_prev[i]) begin
        kept_id_nxt[i]   = id_up[i];
        kept_dist_nxt[i] = dist_up[i];
      end else begin
        kept_id_nxt[i]   = s2_id_r;
        kept_dist_nxt[i] = s2_dist_r;
      end
    end
  end

  // a full store drops its largest entry, so the count holds
  assign kept_cnt_nxt = full ? kept_cnt_r : kept_cnt_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= K_RESET;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      acc_r      <= '0;
      kept_cnt_r <= '0;
      sh_cnt_r   <= '0;
      sh_empty_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_r <= cfg_wdata;
      end
      if (!hold) begin
        s1_vld_r <= in_valid;
        s2_vld_r <= s1_vld_r;
      end
      acc_r <= acc_nxt;
      if (do_flush) begin
        kept_cnt_r <= '0;
        sh_cnt_r   <= kept_cnt_r;
        sh_empty_r <= (kept_cnt_r == '0);
      end else begin
        if (do_ins) begin
          kept_cnt_r <= kept_cnt_nxt;
        end
        if (emit) begin
          if (sh_empty_r) begin
            sh_empty_r <= 1'b0;
          end else begin
            sh_cnt_r <= sh_cnt_r - CW'(1);
          end
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_data.command;
      s1_last_r <= in_data.last_component;
      s1_id_r   <= in_data.candidate_id;
      s1_sq_r   <= sq_full[SQ_W-1:0];
    end
    if (s1_fire) begin
      s2_flush_r <= (s1_cmd_r == CMD_FLUSH);
      s2_ins_r   <= (s1_cmd_r == CMD_COMPONENT) && s1_last_r;
      s2_id_r    <= s1_id_r;
      s2_dist_r  <= sat;
    end
    if (do_ins) begin
      kept_id_r   <= kept_id_nxt;
      kept_dist_r <= kept_dist_nxt;
    end
    if (do_flush) begin
      sh_id_r   <= kept_id_r;
      sh_dist_r <= kept_dist_r;
    end else if (emit && !sh_empty_r) begin
      for (int i = 0; i < MAX_KEPT - 1; i++) begin
        sh_id_r[i]   <= sh_id_r[i+1];
        sh_dist_r[i] <= sh_dist_r[i+1];
      end
    end
    if (emit) begin
      if (sh_empty_r) begin
        out_data_r.result_id       <= '0;
        out_data_r.result_distance <= '0;
        out_data_r.result_valid    <= 1'b0;
        out_data_r.last_result     <= 1'b1;
      end else begin
        out_data_r.result_id       <= sh_id_r[0];
        out_data_r.result_distance <= sh_dist_r[0];
        out_data_r.result_valid    <= 1'b1;
        out_data_r.last_result     <= (sh_cnt_r == CW'(1));
      end
    end
  end

endmodule

@@ rtl/core/knds_checker.sv @@
module knds_checker
  import knds_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input is only stalled while a flush drains, which fills an empty output
  a_stall_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_valid |=> out_valid)
    else $error("input stalled with nothing draining");

  // results of one flush follow back to back in ascending distance
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_result |=>
      out_valid && out_data.result_valid &&
      (out_data.result_distance >= $past(out_data.result_distance)))
    else $error("flush results out of order or broken");

  // the empty-store result ends its flush and carries zero id and distance
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.result_valid |->
      out_data.last_result && (out_data.result_id == '0) &&
      (out_data.result_distance == '0))
    else $error("malformed empty result");

endmodule

bind k_nearest_distance_selector knds_checker u_knds_checker (.*);
